@@ hdl/fte_pkg.sv @@
// Shared types, constants and helper functions for the Fenwick tree engine.
// Used by fte_alu, fte_seq and fenwick_tree_engine; depends on nothing.
package fte_pkg;

  localparam int MAX_SIZE = 1024;
  localparam int ADDR_W   = $clog2(MAX_SIZE);
  localparam int SIZE_W   = $clog2(MAX_SIZE + 1);
  localparam int DATA_W   = 64;
  localparam int TS_W     = 11;
  localparam int IDX_W    = 10;
  localparam int PADDR_W  = 3;

  localparam logic [TS_W-1:0]    TREE_SIZE_RESET = TS_W'(1024);
  localparam logic [PADDR_W-1:0] REG_TREE_SIZE   = PADDR_W'(0);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_PREFIX = 2'd1,
    OP_RANGE  = 2'd2,
    OP_SELECT = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_SEL_RD,
    ST_SEL_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              sub;
    logic [DATA_W-1:0] target;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic              less;
  } alu_rsp_t;

  // tree_size clamped to 1..MAX_SIZE
  function automatic logic [SIZE_W-1:0] eff_size(input logic [TS_W-1:0] ts);
    logic [SIZE_W-1:0] r;
    if (ts == '0) begin
      r = SIZE_W'(1);
    end else if (int'(ts) > MAX_SIZE) begin
      r = SIZE_W'(MAX_SIZE);
    end else begin
      r = SIZE_W'(ts);
    end
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] low_bit(input logic [SIZE_W-1:0] p);
    return p & (~p + SIZE_W'(1));
  endfunction

  // highest power of two not above s
  function automatic logic [SIZE_W-1:0] high_pow(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = SIZE_W'(1);
    for (int i = 0; i < SIZE_W; i++) begin
      if (s[i]) r = SIZE_W'(1) << i;
    end
    return r;
  endfunction

endpackage

@@ hdl/fte_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fte_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/fte_alu.sv @@
// Shared 64-bit add/subtract unit with signed compare against a target.
// Depends on fte_pkg.
module fte_alu (
  input  fte_pkg::alu_req_t req,
  output fte_pkg::alu_rsp_t rsp
);

  logic [fte_pkg::DATA_W-1:0] b_op;

  assign b_op     = req.sub ? ~req.b : req.b;
  assign rsp.sum  = req.a + b_op + fte_pkg::DATA_W'(req.sub);
  assign rsp.less = $signed(rsp.sum) < $signed(req.target);

endmodule

@@ hdl/fte_seq.sv @@
// Sequencer for the tree walks: clear pass, point add, prefix/range sum and select.
// Drives the tree RAM ports and one shared fte_alu. Depends on fte_pkg, fte_alu.
module fte_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clr_start,
  input  logic [fte_pkg::SIZE_W-1:0]        size,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        opcode,
  input  logic [fte_pkg::IDX_W-1:0]         index,
  input  logic [fte_pkg::IDX_W-1:0]         right_index,
  input  logic signed [fte_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fte_pkg::DATA_W-1:0] sum_result,
  output logic [fte_pkg::SIZE_W-1:0]        position,
  output logic                              error,
  output logic                              ram_we,
  output logic [fte_pkg::ADDR_W-1:0]        ram_waddr,
  output logic [fte_pkg::DATA_W-1:0]        ram_wdata,
  output logic [fte_pkg::ADDR_W-1:0]        ram_raddr,
  input  logic [fte_pkg::DATA_W-1:0]        ram_rdata
);

  localparam int SW = fte_pkg::SIZE_W;

  fte_pkg::state_t state, state_next;
  fte_pkg::op_t    op, op_next;
  logic            err, err_next;
  logic            phase2, phase2_next;
  logic [SW-1:0]   pos, pos_next;
  logic [SW-1:0]   x, x_next;
  logic [SW-1:0]   step, step_next;
  logic [fte_pkg::IDX_W-1:0]  left, left_next;
  logic [fte_pkg::DATA_W-1:0] delta, delta_next;
  logic [fte_pkg::DATA_W-1:0] acc, acc_next;
  logic [fte_pkg::ADDR_W-1:0] clr_addr, clr_addr_next;

  fte_pkg::alu_req_t alu_req;
  fte_pkg::alu_rsp_t alu_rsp;

  logic          take;
  logic          out_free;
  logic [SW:0]   add_np;
  logic [SW-1:0] sum_np;
  logic [SW:0]   sel_xs;
  logic [SW:0]   idx_ext;
  logic [SW:0]   right_ext;
  logic [SW:0]   size_ext;

  fte_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_stall  = (state != fte_pkg::ST_IDLE);
  assign take      = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign add_np    = {1'b0, pos} + {1'b0, fte_pkg::low_bit(pos)};
  assign sum_np    = pos - fte_pkg::low_bit(pos);
  assign sel_xs    = {1'b0, x} + {1'b0, step};
  assign idx_ext   = (SW+1)'(index);
  assign right_ext = (SW+1)'(right_index);
  assign size_ext  = {1'b0, size};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fte_pkg::ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      if (state == fte_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    op     <= op_next;
    err    <= err_next;
    phase2 <= phase2_next;
    pos    <= pos_next;
    x      <= x_next;
    step   <= step_next;
    left   <= left_next;
    delta  <= delta_next;
    acc    <= acc_next;
    if (state == fte_pkg::ST_DONE && out_free) begin
      sum_result <= ((op == fte_pkg::OP_PREFIX || op == fte_pkg::OP_RANGE) && !err) ?
                    acc : '0;
      position   <= (op == fte_pkg::OP_SELECT) ? x + SW'(1) : '0;
      error      <= err;
    end
  end

  always_comb begin
    state_next    = state;
    op_next       = op;
    err_next      = err;
    phase2_next   = phase2;
    pos_next      = pos;
    x_next        = x;
    step_next     = step;
    left_next     = left;
    delta_next    = delta;
    acc_next      = acc;
    clr_addr_next = clr_addr;
    ram_we        = 1'b0;
    ram_waddr     = pos[fte_pkg::ADDR_W-1:0];
    ram_wdata     = alu_rsp.sum;
    ram_raddr     = pos[fte_pkg::ADDR_W-1:0];
    alu_req.a      = acc;
    alu_req.b      = ram_rdata;
    alu_req.sub    = 1'b0;
    alu_req.target = delta;

    case (state)
      fte_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == fte_pkg::ADDR_W'(fte_pkg::MAX_SIZE - 1)) begin
          clr_addr_next = '0;
          state_next    = fte_pkg::ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + fte_pkg::ADDR_W'(1);
        end
      end
      fte_pkg::ST_IDLE: begin
        if (take) begin
          op_next     = fte_pkg::op_t'(opcode);
          delta_next  = value;
          acc_next    = '0;
          x_next      = '0;
          phase2_next = 1'b0;
          left_next   = index;
          err_next    = 1'b0;
          case (fte_pkg::op_t'(opcode))
            fte_pkg::OP_ADD: begin
              pos_next = SW'(index);
              if (index == '0 || idx_ext >= size_ext) begin
                err_next   = 1'b1;
                state_next = fte_pkg::ST_DONE;
              end else begin
                state_next = fte_pkg::ST_ADD_RD;
              end
            end
            fte_pkg::OP_PREFIX: begin
              pos_next = SW'(index);
              if (idx_ext >= size_ext) begin
                err_next   = 1'b1;
                state_next = fte_pkg::ST_DONE;
              end else begin
                state_next = fte_pkg::ST_SUM_RD;
              end
            end
            fte_pkg::OP_RANGE: begin
              pos_next = SW'(right_index);
              if (index == '0 || right_ext >= size_ext || idx_ext > size_ext) begin
                err_next   = 1'b1;
                state_next = fte_pkg::ST_DONE;
              end else begin
                state_next = fte_pkg::ST_SUM_RD;
              end
            end
            default: begin
              step_next  = fte_pkg::high_pow(size);
              state_next = fte_pkg::ST_SEL_RD;
            end
          endcase
        end
      end
      fte_pkg::ST_ADD_RD: begin
        state_next = fte_pkg::ST_ADD_WR;
      end
      fte_pkg::ST_ADD_WR: begin
        alu_req.a = ram_rdata;
        alu_req.b = delta;
        ram_we    = 1'b1;
        if (add_np < size_ext) begin
          pos_next  = add_np[SW-1:0];
          ram_raddr = add_np[fte_pkg::ADDR_W-1:0];
        end else begin
          state_next = fte_pkg::ST_DONE;
        end
      end
      fte_pkg::ST_SUM_RD: begin
        if (pos != '0 && pos < size) begin
          state_next = fte_pkg::ST_SUM_ACC;
        end else if (op == fte_pkg::OP_RANGE && !phase2) begin
          phase2_next = 1'b1;
          pos_next    = SW'(left) - SW'(1);
        end else begin
          state_next = fte_pkg::ST_DONE;
        end
      end
      fte_pkg::ST_SUM_ACC: begin
        alu_req.sub = phase2;
        acc_next    = alu_rsp.sum;
        pos_next    = sum_np;
        ram_raddr   = sum_np[fte_pkg::ADDR_W-1:0];
        if (sum_np == '0) begin
          state_next = fte_pkg::ST_SUM_RD;
        end
      end
      fte_pkg::ST_SEL_RD: begin
        ram_raddr = sel_xs[fte_pkg::ADDR_W-1:0];
        if (step == '0) begin
          state_next = fte_pkg::ST_DONE;
        end else if (sel_xs < size_ext) begin
          state_next = fte_pkg::ST_SEL_CMP;
        end else begin
          step_next = step >> 1;
        end
      end
      fte_pkg::ST_SEL_CMP: begin
        if (alu_rsp.less) begin
          x_next   = sel_xs[SW-1:0];
          acc_next = alu_rsp.sum;
        end
        step_next  = step >> 1;
        state_next = fte_pkg::ST_SEL_RD;
      end
      fte_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = fte_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fte_pkg::ST_IDLE;
      end
    endcase

    if (clr_start) begin
      state_next    = fte_pkg::ST_CLEAR;
      clr_addr_next = '0;
    end
  end

`ifndef SYNTHESIS
  a_we_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == fte_pkg::ST_CLEAR || state == fte_pkg::ST_ADD_WR))
    else $error("tree written outside clear or add");

  a_add_pos: assert property (@(posedge clk) disable iff (rst)
    state == fte_pkg::ST_ADD_WR |-> (pos != '0 && pos < size))
    else $error("add walk left the valid range");

  a_clr_walk: assert property (@(posedge clk) disable iff (rst)
    (state == fte_pkg::ST_CLEAR && !clr_start && clr_addr != '1) |=>
    (state == fte_pkg::ST_CLEAR && clr_addr == $past(clr_addr) + fte_pkg::ADDR_W'(1)))
    else $error("clear pass skipped an entry");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (sum_result == '0 && position == '0))
    else $error("error result carries data");
`endif

endmodule

@@ hdl/fenwick_tree_engine.sv @@
// Fenwick tree engine top level: APB size register, sequencer and tree RAM.
// An add walks the update chain of nodes, a prefix sum walks the query chain, a range
// sum walks both chains and a select descends over powers of two. One item in flight:
// the next transfer can be taken in the same cycle the result is presented, and an
// output stall delays both. Reset (synchronous) and every tree_size write start a
// clear pass over the whole tree RAM. Depends on fte_pkg, fte_ram, fte_alu, fte_seq.
module fenwick_tree_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fte_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          opcode,
  input  logic [fte_pkg::IDX_W-1:0]           index,
  input  logic [fte_pkg::IDX_W-1:0]           right_index,
  input  logic signed [fte_pkg::DATA_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fte_pkg::DATA_W-1:0]   sum_result,
  output logic [fte_pkg::SIZE_W-1:0]          position,
  output logic                                error
);

  logic [fte_pkg::TS_W-1:0]   tree_size;
  logic                       size_wr;
  logic                       ram_we;
  logic [fte_pkg::ADDR_W-1:0] ram_waddr;
  logic [fte_pkg::DATA_W-1:0] ram_wdata;
  logic [fte_pkg::ADDR_W-1:0] ram_raddr;
  logic [fte_pkg::DATA_W-1:0] ram_rdata;

  assign pready  = 1'b1;
  assign size_wr = psel && penable && pwrite &&
                   ((paddr & ~fte_pkg::PADDR_W'(3)) == fte_pkg::REG_TREE_SIZE);
  assign prdata  = ((paddr & ~fte_pkg::PADDR_W'(3)) == fte_pkg::REG_TREE_SIZE) ?
                   32'(tree_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tree_size <= fte_pkg::TREE_SIZE_RESET;
    end else if (size_wr) begin
      tree_size <= pwdata[fte_pkg::TS_W-1:0];
    end
  end

  fte_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .clr_start   (size_wr),
    .size        (fte_pkg::eff_size(tree_size)),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .index       (index),
    .right_index (right_index),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sum_result  (sum_result),
    .position    (position),
    .error       (error),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  fte_ram #(
    .WIDTH (fte_pkg::DATA_W),
    .DEPTH (fte_pkg::MAX_SIZE)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
